>>> hw/rtl/idst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idst_pkg;

  typedef enum logic [1:0] {
    FN_ARM     = 2'd0,
    FN_TAKE    = 2'd1,
    FN_RELEASE = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_ARMED = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/interrupt_delivery_slot_table.sv
// Channel  Direction  Handshake              Word
// in       input      in_valid / in_ready    func, driver_id, source_id, service_word
// out      output     out_valid / out_ready  status, present, service_out
//
// Each word is captured and matched against all slots at once in S_IDLE, then
// written back to the table and loaded into the output register in S_EXEC.
// The next word is accepted in the cycle after the write-back, even while a
// result still waits in the output register; a stalled result holds the
// write-back of the following word. Reset (rst_n low at a clock edge) clears
// every slot to unoccupied at once.
`timescale 1ns / 1ps
`default_nettype none

module interrupt_delivery_slot_table
  import idst_pkg::*;
#(
  parameter int SLOT_COUNT   = 8,
  parameter int DRIVER_BITS  = 16,
  parameter int SERVICE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_func,
  input  wire logic [DRIVER_BITS-1:0]  in_driver_id,
  input  wire logic [7:0]              in_source_id,
  input  wire logic [SERVICE_BITS-1:0] in_service_word,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_status,
  output logic                         out_present,
  output logic [SERVICE_BITS-1:0]      out_service_out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  idst_datapath #(
    .SLOT_COUNT   (SLOT_COUNT),
    .DRIVER_BITS  (DRIVER_BITS),
    .SERVICE_BITS (SERVICE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_driver_id    (in_driver_id),
    .in_source_id    (in_source_id),
    .in_service_word (in_service_word),
    .out_status      (out_status),
    .out_present     (out_present),
    .out_service_out (out_service_out)
  );

endmodule

`default_nettype wire

>>> hw/rtl/idst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module idst_ctrl
  import idst_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  output logic          out_valid,
  output dp_cmd_t       cmd,
  output dp_stat_t      stat
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_full = out_valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/idst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module idst_datapath
  import idst_pkg::*;
#(
  parameter int SLOT_COUNT   = 8,
  parameter int DRIVER_BITS  = 16,
  parameter int SERVICE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 cmd,
  input  wire dp_stat_t                stat,
  input  wire logic [1:0]              in_func,
  input  wire logic [DRIVER_BITS-1:0]  in_driver_id,
  input  wire logic [7:0]              in_source_id,
  input  wire logic [SERVICE_BITS-1:0] in_service_word,
  output logic [2:0]                   out_status,
  output logic                         out_present,
  output logic [SERVICE_BITS-1:0]      out_service_out
);

  localparam int IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0]   valid_r;
  logic [DRIVER_BITS-1:0]  driver_r [SLOT_COUNT];
  logic [SERVICE_BITS-1:0] svc_mem  [SLOT_COUNT];

  func_t                   req_func_r;
  logic [DRIVER_BITS-1:0]  req_id_r;
  logic                    req_bad_r;
  logic [SERVICE_BITS-1:0] req_svc_r;
  logic                    hit_r;
  logic [IDX_BITS-1:0]     hit_idx_r;
  logic                    full_r;
  logic [IDX_BITS-1:0]     free_idx_r;
  logic [SERVICE_BITS-1:0] rd_data_r;

  status_t                 out_status_r;
  logic                    out_present_r;
  logic [SERVICE_BITS-1:0] out_service_r;

  logic [SLOT_COUNT-1:0] match_c;
  logic                  hit_c;
  logic [IDX_BITS-1:0]   hit_idx_c;
  logic                  any_free_c;
  logic [IDX_BITS-1:0]   free_idx_c;

  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    any_free_c = 1'b0;
    free_idx_c = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      match_c[i] = valid_r[i] && (driver_r[i] == in_driver_id) && (in_driver_id != '0);
      if (match_c[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_BITS'(i);
      end
      if (!valid_r[i]) begin
        any_free_c = 1'b1;
        free_idx_c = IDX_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func_r <= func_t'(in_func);
      req_id_r   <= in_driver_id;
      req_bad_r  <= (in_driver_id == '0) || (in_source_id == 8'd0);
      req_svc_r  <= in_service_word;
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      full_r     <= !any_free_c;
      free_idx_r <= free_idx_c;
      rd_data_r  <= svc_mem[hit_idx_c];
    end
  end

  status_t                 status_c;
  logic                    do_arm_c;
  logic                    do_clear_c;
  logic [SERVICE_BITS-1:0] sout_c;

  always_comb begin
    status_c   = ST_OK;
    do_arm_c   = 1'b0;
    do_clear_c = 1'b0;
    sout_c     = '0;
    unique case (req_func_r)
      FN_ARM: begin
        priority if (req_bad_r) begin
          status_c = ST_INVALID;
        end else if (hit_r) begin
          status_c = ST_DUPLICATE;
        end else if (full_r) begin
          status_c = ST_FULL;
        end else begin
          do_arm_c = 1'b1;
        end
      end
      FN_TAKE: begin
        if (!hit_r) begin
          status_c = ST_NOT_ARMED;
        end else begin
          do_clear_c = 1'b1;
          sout_c     = rd_data_r;
        end
      end
      FN_RELEASE: begin
        if (!hit_r) begin
          status_c = ST_NOT_ARMED;
        end else begin
          do_clear_c = 1'b1;
        end
      end
      FN_QUERY: status_c = ST_OK;
      default:  status_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (do_arm_c) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (do_clear_c) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_arm_c) begin
      driver_r[free_idx_r] <= req_id_r;
      svc_mem[free_idx_r]  <= req_svc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= status_c;
      out_present_r <= hit_r;
      out_service_r <= sout_c;
    end else if (!stat.out_full) begin
      out_service_r <= '0;
    end
  end

  assign out_status      = out_status_r;
  assign out_present     = out_present_r;
  assign out_service_out = out_service_r;

endmodule

`default_nettype wire

>>> hw/rtl/idst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module idst_checker
  import idst_pkg::*;
#(
  parameter int DRIVER_BITS  = 16,
  parameter int SERVICE_BITS = 32
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [1:0]              in_func,
  input wire logic [DRIVER_BITS-1:0]  in_driver_id,
  input wire logic [7:0]              in_source_id,
  input wire logic [SERVICE_BITS-1:0] in_service_word,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [2:0]              out_status,
  input wire logic                    out_present,
  input wire logic [SERVICE_BITS-1:0] out_service_out
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_present) && $stable(out_service_out)))
    else $error("stalled result changed");

  a_service_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_service_out != '0)) |-> (out_status == ST_OK && out_present))
    else $error("service word returned without a successful match");

  a_status_vs_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_DUPLICATE && out_present) ||
                   (out_status == ST_NOT_ARMED && !out_present) ||
                   out_status == ST_OK || out_status == ST_INVALID ||
                   (out_status == ST_FULL && !out_present)))
    else $error("status disagrees with present flag");

endmodule

bind interrupt_delivery_slot_table idst_checker #(
  .DRIVER_BITS  (DRIVER_BITS),
  .SERVICE_BITS (SERVICE_BITS)
) u_idst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_func         (in_func),
  .in_driver_id    (in_driver_id),
  .in_source_id    (in_source_id),
  .in_service_word (in_service_word),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_present     (out_present),
  .out_service_out (out_service_out)
);

`default_nettype wire
